/* rtl/sme_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sme_pkg
// shared constants, opcode and status codes and queue types of the stack
// machine execute unit
// ----------------------------------------------------------------------------
package sme_pkg;

    localparam int STACK_DEPTH    = 64;
    localparam int REGISTER_COUNT = 8;
    localparam int RAM_BYTES      = 4096;
    localparam int QUEUE_DEPTH    = 2;

    localparam int DS_AW   = $clog2(STACK_DEPTH);
    localparam int DEPTH_W = DS_AW + 1;
    localparam int REG_AW  = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
    localparam int RAM_AW  = $clog2(RAM_BYTES);
    localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [16:0] PSIZE_MAX = 17'd65536;

    localparam logic [4:0] K_HALT  = 5'd0;
    localparam logic [4:0] K_DRAW  = 5'd1;
    localparam logic [4:0] K_ADD   = 5'd2;
    localparam logic [4:0] K_SUB   = 5'd3;
    localparam logic [4:0] K_MUL   = 5'd4;
    localparam logic [4:0] K_DIV   = 5'd5;
    localparam logic [4:0] K_SQRT  = 5'd6;
    localparam logic [4:0] K_PUSH  = 5'd7;
    localparam logic [4:0] K_OUT   = 5'd8;
    localparam logic [4:0] K_IN    = 5'd9;
    localparam logic [4:0] K_PUSHR = 5'd10;
    localparam logic [4:0] K_POPR  = 5'd11;
    localparam logic [4:0] K_PUSHM = 5'd12;
    localparam logic [4:0] K_POPM  = 5'd13;
    localparam logic [4:0] K_JMP   = 5'd14;
    localparam logic [4:0] K_JB    = 5'd15;
    localparam logic [4:0] K_JBE   = 5'd16;
    localparam logic [4:0] K_JA    = 5'd17;
    localparam logic [4:0] K_JAE   = 5'd18;
    localparam logic [4:0] K_JE    = 5'd19;
    localparam logic [4:0] K_JNE   = 5'd20;
    localparam logic [4:0] K_CALL  = 5'd21;
    localparam logic [4:0] K_RET   = 5'd22;

    localparam logic [2:0] S_OK     = 3'd0;
    localparam logic [2:0] S_HALT   = 3'd1;
    localparam logic [2:0] S_STACK  = 3'd2;
    localparam logic [2:0] S_DIV0   = 3'd3;
    localparam logic [2:0] S_BADREG = 3'd4;
    localparam logic [2:0] S_BADRAM = 3'd5;
    localparam logic [2:0] S_BADTGT = 3'd6;

    typedef struct packed {
        logic is_bin;
        logic is_cond;
        logic reg_ok;
        logic tgt_ok;
    } t_cls;

    typedef struct packed {
        logic [4:0]  kind;
        logic [31:0] imm;
        logic [15:0] op;
        logic [31:0] inv;
        t_cls        cls;
    } t_item;

    function automatic logic target_ok(input logic [31:0] t, input logic [16:0] psize);
        logic [16:0] bound;
        bound = (psize > PSIZE_MAX) ? PSIZE_MAX : psize;
        return (t[31:16] == 16'd0) && ({1'b0, t[15:0]} < bound);
    endfunction

endpackage
`default_nettype wire

/* rtl/sme_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sme_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module sme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* rtl/sme_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sme_front
// accepts instruction transactions, classifies them and queues them for
// the execution back end
// ----------------------------------------------------------------------------
module sme_front
    import sme_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [4:0]  i_kind,
    input  wire logic [31:0] i_immediate,
    input  wire logic [15:0] i_operand_address,
    input  wire logic [31:0] i_in_value,
    input  wire logic [16:0] i_program_size,
    input  wire logic        i_hold,
    input  wire logic        i_pop,
    output logic             o_q_valid,
    output t_item            o_item
);
    t_item              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wptr;
    logic [QPTR_W-1:0]  r_rptr;
    logic [QCNT_W-1:0]  r_cnt;
    logic               accept;
    t_item              item;

    assign o_in_stall = (r_cnt == QCNT_W'(QUEUE_DEPTH)) || i_hold;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_cnt != '0);
    assign o_item     = r_q[r_rptr];

    always_comb begin
        item.kind        = i_kind;
        item.imm         = i_immediate;
        item.op          = i_operand_address;
        item.inv         = i_in_value;
        item.cls.is_bin  = (i_kind == K_ADD) || (i_kind == K_SUB) || (i_kind == K_MUL);
        item.cls.is_cond = (i_kind == K_JB) || (i_kind == K_JBE) || (i_kind == K_JA)
                        || (i_kind == K_JAE) || (i_kind == K_JE) || (i_kind == K_JNE);
        item.cls.reg_ok  = (i_immediate < 32'(REGISTER_COUNT));
        item.cls.tgt_ok  = target_ok(i_immediate, i_program_size);
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wptr] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (accept) begin
                r_wptr <= (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_W'(accept) - QCNT_W'(i_pop);
        end
    end
endmodule
`default_nettype wire

/* rtl/sme_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sme_back
// executes queued instructions: stacks, registers, byte ram, iterative
// divider and root unit, result register
// ----------------------------------------------------------------------------
module sme_back
    import sme_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [16:0] i_program_size,
    input  wire logic        i_q_valid,
    input  wire t_item       i_item,
    output logic             o_pop,
    output logic             o_hold,
    output logic             o_res_valid,
    input  wire logic        i_res_stall,
    output logic [2:0]       o_status,
    output logic [15:0]      o_next_address,
    output logic             o_out_valid,
    output logic [31:0]      o_out_value
);
    localparam logic [3:0] ST_CLR  = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_RD1  = 4'd2;
    localparam logic [3:0] ST_RD2  = 4'd3;
    localparam logic [3:0] ST_WB   = 4'd4;
    localparam logic [3:0] ST_DIV  = 4'd5;
    localparam logic [3:0] ST_SQRT = 4'd6;
    localparam logic [3:0] ST_RAM  = 4'd7;
    localparam logic [3:0] ST_RET  = 4'd8;

    logic [3:0]         r_state, n_state;
    logic [4:0]         r_kind, n_kind;
    logic [31:0]        r_imm, n_imm;
    logic [15:0]        r_op, n_op;
    t_cls               r_cls, n_cls;
    logic [31:0]        r_a, n_a;
    logic [31:0]        r_b, n_b;
    logic [31:0]        r_res, n_res;
    logic [31:0]        r_rem, n_rem;
    logic [31:0]        r_bit, n_bit;
    logic [4:0]         r_cnt, n_cnt;
    logic               r_neg, n_neg;
    logic               r_dec, n_dec;
    logic [DEPTH_W-1:0] r_dd, n_dd;
    logic [DEPTH_W-1:0] r_rd, n_rd;
    logic [RAM_AW:0]    r_clr, n_clr;
    logic [31:0]        r_regs [REGISTER_COUNT];
    logic               r_o_valid, n_o_valid;
    logic [2:0]         r_o_status, n_o_status;
    logic [15:0]        r_o_next, n_o_next;
    logic               r_o_ov, n_o_ov;
    logic [31:0]        r_o_oval, n_o_oval;

    logic               fin;
    logic [2:0]         fin_status;
    logic [15:0]        fin_next;
    logic               fin_ov;
    logic [31:0]        fin_oval;

    logic               ds_we;
    logic [DS_AW-1:0]   ds_waddr, ds_raddr;
    logic [31:0]        ds_wdata, ds_rdata;
    logic               rs_we;
    logic [DS_AW-1:0]   rs_waddr, rs_raddr;
    logic [15:0]        rs_wdata, rs_rdata;
    logic               br_we;
    logic [RAM_AW-1:0]  br_waddr, br_raddr;
    logic [7:0]         br_wdata, br_rdata;
    logic               reg_we;
    logic [31:0]        reg_wdata;

    logic               out_free;
    logic               full, rfull;
    logic [15:0]        op4;
    logic [31:0]        regval;
    logic               ramok;
    logic               taken;
    logic [32:0]        rem_sh;
    logic [31:0]        q_new;
    logic [31:0]        sq_try;
    logic [16:0]        bound;

    sme_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ds (
        .i_clk(i_clk), .i_we(ds_we), .i_waddr(ds_waddr), .i_wdata(ds_wdata),
        .i_raddr(ds_raddr), .o_rdata(ds_rdata)
    );
    sme_ram #(.WIDTH(16), .DEPTH(STACK_DEPTH)) u_rs (
        .i_clk(i_clk), .i_we(rs_we), .i_waddr(rs_waddr), .i_wdata(rs_wdata),
        .i_raddr(rs_raddr), .o_rdata(rs_rdata)
    );
    sme_ram #(.WIDTH(8), .DEPTH(RAM_BYTES)) u_br (
        .i_clk(i_clk), .i_we(br_we), .i_waddr(br_waddr), .i_wdata(br_wdata),
        .i_raddr(br_raddr), .o_rdata(br_rdata)
    );

    assign out_free = !r_o_valid || !i_res_stall;
    assign full     = (r_dd == DEPTH_W'(STACK_DEPTH));
    assign rfull    = (r_rd == DEPTH_W'(STACK_DEPTH));
    assign op4      = i_item.op + 16'd4;
    assign regval   = r_regs[i_item.imm[REG_AW-1:0]];
    assign ramok    = (regval < 32'(RAM_BYTES));
    assign bound    = (i_program_size > PSIZE_MAX) ? PSIZE_MAX : i_program_size;
    assign o_hold   = (r_state == ST_CLR);
    assign rem_sh   = {r_rem, r_a[31]};
    assign sq_try   = r_res + r_bit;

    always_comb begin
        case (r_kind)
            K_JB:    taken = $signed(ds_rdata) < $signed(r_b);
            K_JBE:   taken = !($signed(r_b) < $signed(ds_rdata));
            K_JA:    taken = $signed(r_b) < $signed(ds_rdata);
            K_JAE:   taken = !($signed(ds_rdata) < $signed(r_b));
            K_JE:    taken = ds_rdata == r_b;
            default: taken = ds_rdata != r_b;
        endcase
    end

    always_comb begin
        n_state = r_state; n_kind = r_kind; n_imm = r_imm; n_op = r_op; n_cls = r_cls;
        n_a = r_a; n_b = r_b; n_res = r_res; n_rem = r_rem; n_bit = r_bit;
        n_cnt = r_cnt; n_neg = r_neg; n_dec = r_dec; n_dd = r_dd; n_rd = r_rd;
        n_clr = r_clr;
        fin = 1'b0; fin_status = S_OK; fin_next = r_op; fin_ov = 1'b0; fin_oval = '0;
        o_pop = 1'b0;
        ds_we = 1'b0; ds_waddr = DS_AW'(r_dd); ds_wdata = '0;
        ds_raddr = DS_AW'(r_dd - 1'b1);
        rs_we = 1'b0; rs_waddr = DS_AW'(r_rd); rs_wdata = '0;
        rs_raddr = DS_AW'(r_rd - 1'b1);
        br_we = 1'b0; br_waddr = r_a[RAM_AW-1:0]; br_wdata = '0;
        br_raddr = regval[RAM_AW-1:0];
        reg_we = 1'b0; reg_wdata = ds_rdata;
        q_new = '0;

        case (r_state)
            ST_CLR: begin
                br_we    = 1'b1;
                br_waddr = r_clr[RAM_AW-1:0];
                n_clr    = r_clr + 1'b1;
                if (r_clr == (RAM_AW+1)'(RAM_BYTES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_pop = 1'b1;
                    n_kind = i_item.kind; n_imm = i_item.imm;
                    n_op = i_item.op; n_cls = i_item.cls;
                    fin_next = i_item.op;
                    if (i_item.cls.is_bin || i_item.cls.is_cond) begin
                        if (r_dd < DEPTH_W'(2)) begin
                            fin = 1'b1; fin_status = S_STACK;
                        end else begin
                            n_state = ST_RD1;
                        end
                    end else begin
                        case (i_item.kind)
                            K_HALT: begin
                                fin = 1'b1; fin_status = S_HALT;
                            end
                            K_DRAW: begin
                                fin = 1'b1;
                            end
                            K_DIV, K_SQRT, K_OUT: begin
                                if (r_dd == '0) begin
                                    fin = 1'b1; fin_status = S_STACK;
                                end else begin
                                    n_state = ST_RD1;
                                end
                            end
                            K_PUSH, K_IN: begin
                                fin = 1'b1;
                                if (i_item.kind == K_PUSH) fin_next = op4;
                                if (full) begin
                                    fin_status = S_STACK;
                                end else begin
                                    ds_we    = 1'b1;
                                    ds_wdata = (i_item.kind == K_PUSH) ? i_item.imm : i_item.inv;
                                    n_dd     = r_dd + 1'b1;
                                end
                            end
                            K_PUSHR: begin
                                fin = 1'b1;
                                if (!i_item.cls.reg_ok) begin
                                    fin_status = S_BADREG;
                                end else if (full) begin
                                    fin_status = S_STACK; fin_next = op4;
                                end else begin
                                    fin_next = op4;
                                    ds_we = 1'b1; ds_wdata = regval;
                                    n_dd = r_dd + 1'b1;
                                end
                            end
                            K_POPR: begin
                                if (!i_item.cls.reg_ok) begin
                                    fin = 1'b1; fin_status = S_BADREG;
                                end else if (r_dd == '0) begin
                                    fin = 1'b1; fin_status = S_STACK; fin_next = op4;
                                end else begin
                                    n_state = ST_RD1;
                                end
                            end
                            K_PUSHM: begin
                                if (!i_item.cls.reg_ok) begin
                                    fin = 1'b1; fin_status = S_BADREG;
                                end else if (!ramok) begin
                                    fin = 1'b1; fin_status = S_BADRAM; fin_next = op4;
                                end else if (full) begin
                                    fin = 1'b1; fin_status = S_STACK; fin_next = op4;
                                end else begin
                                    n_state = ST_RAM;
                                end
                            end
                            K_POPM: begin
                                n_a = regval;
                                if (!i_item.cls.reg_ok) begin
                                    fin = 1'b1; fin_status = S_BADREG;
                                end else if (!ramok) begin
                                    fin = 1'b1; fin_status = S_BADRAM;
                                end else if (r_dd == '0) begin
                                    fin = 1'b1; fin_status = S_STACK; fin_next = op4;
                                end else begin
                                    n_state = ST_RD1;
                                end
                            end
                            K_JMP: begin
                                fin = 1'b1;
                                if (!i_item.cls.tgt_ok) fin_status = S_BADTGT;
                                else fin_next = i_item.imm[15:0];
                            end
                            K_CALL: begin
                                fin = 1'b1;
                                if (rfull) begin
                                    fin_status = S_STACK;
                                end else if (!i_item.cls.tgt_ok) begin
                                    fin_status = S_BADTGT;
                                end else begin
                                    rs_we = 1'b1; rs_wdata = op4;
                                    n_rd = r_rd + 1'b1;
                                    fin_next = i_item.imm[15:0];
                                end
                            end
                            K_RET: begin
                                if (r_rd == '0) begin
                                    fin = 1'b1; fin_status = S_STACK;
                                end else begin
                                    n_state = ST_RET;
                                end
                            end
                            default: begin
                                fin = 1'b1; fin_status = S_BADTGT;
                            end
                        endcase
                    end
                end
            end
            ST_RD1: begin
                n_b = ds_rdata;
                ds_raddr = DS_AW'(r_dd - 2'd2);
                if (r_cls.is_bin || r_cls.is_cond) begin
                    n_state = ST_RD2;
                end else begin
                    case (r_kind)
                        K_DIV: begin
                            if (ds_rdata == '0) begin
                                fin = 1'b1; fin_status = S_DIV0;
                            end else if (r_dd < DEPTH_W'(2)) begin
                                fin = 1'b1; fin_status = S_STACK;
                            end else begin
                                n_state = ST_RD2;
                            end
                        end
                        K_SQRT: begin
                            n_dec = 1'b0; n_res = '0;
                            if (ds_rdata[31]) begin
                                n_state = ST_WB;
                            end else begin
                                n_a = ds_rdata; n_bit = 32'h4000_0000;
                                n_cnt = '0; n_state = ST_SQRT;
                            end
                        end
                        K_OUT: begin
                            n_dd = r_dd - 1'b1;
                            fin = 1'b1; fin_ov = 1'b1; fin_oval = ds_rdata;
                        end
                        K_POPR: begin
                            reg_we = 1'b1;
                            n_dd = r_dd - 1'b1;
                            fin = 1'b1; fin_next = r_op + 16'd4;
                        end
                        K_POPM: begin
                            br_we = 1'b1; br_wdata = ds_rdata[7:0];
                            n_dd = r_dd - 1'b1;
                            fin = 1'b1; fin_next = r_op + 16'd4;
                        end
                        default: begin
                            fin = 1'b1; fin_status = S_BADTGT;
                        end
                    endcase
                end
            end
            ST_RD2: begin
                n_dec = 1'b1;
                n_state = ST_WB;
                case (r_kind)
                    K_ADD: n_res = ds_rdata + r_b;
                    K_SUB: n_res = ds_rdata - r_b;
                    K_MUL: n_res = ds_rdata * r_b;
                    K_DIV: begin
                        n_a = ds_rdata[31] ? (32'd0 - ds_rdata) : ds_rdata;
                        n_b = r_b[31] ? (32'd0 - r_b) : r_b;
                        n_neg = ds_rdata[31] ^ r_b[31];
                        n_rem = '0; n_cnt = '0;
                        n_state = ST_DIV;
                    end
                    default: begin
                        n_state = ST_IDLE;
                        fin = 1'b1;
                        if (taken && !r_cls.tgt_ok) begin
                            fin_status = S_BADTGT;
                        end else begin
                            n_dd = r_dd - 2'd2;
                            fin_next = taken ? r_imm[15:0] : (r_op + 16'd4);
                        end
                    end
                endcase
            end
            ST_DIV: begin
                if (rem_sh >= {1'b0, r_b}) begin
                    n_rem = 32'(rem_sh - {1'b0, r_b});
                    q_new = {r_a[30:0], 1'b1};
                end else begin
                    n_rem = rem_sh[31:0];
                    q_new = {r_a[30:0], 1'b0};
                end
                n_a = q_new;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 5'd31) begin
                    n_res = r_neg ? (32'd0 - q_new) : q_new;
                    n_state = ST_WB;
                end
            end
            ST_SQRT: begin
                if (r_a >= sq_try) begin
                    n_a = r_a - sq_try;
                    n_res = (r_res >> 1) + r_bit;
                end else begin
                    n_res = r_res >> 1;
                end
                n_bit = r_bit >> 2;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 5'd15) n_state = ST_WB;
            end
            ST_WB: begin
                ds_we = 1'b1; ds_wdata = r_res;
                ds_waddr = r_dec ? DS_AW'(r_dd - 2'd2) : DS_AW'(r_dd - 1'b1);
                if (r_dec) n_dd = r_dd - 1'b1;
                fin = 1'b1;
            end
            ST_RAM: begin
                ds_we = 1'b1; ds_wdata = {{24{br_rdata[7]}}, br_rdata};
                n_dd = r_dd + 1'b1;
                fin = 1'b1; fin_next = r_op + 16'd4;
            end
            ST_RET: begin
                fin = 1'b1;
                if ({1'b0, rs_rdata} < bound) begin
                    n_rd = r_rd - 1'b1; fin_next = rs_rdata;
                end else begin
                    fin_status = S_BADTGT;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (fin && (r_state != ST_CLR)) n_state = ST_IDLE;

        n_o_valid = r_o_valid && i_res_stall;
        n_o_status = r_o_status; n_o_next = r_o_next;
        n_o_ov = r_o_ov; n_o_oval = r_o_oval;
        if (fin) begin
            n_o_valid = 1'b1; n_o_status = fin_status; n_o_next = fin_next;
            n_o_ov = fin_ov; n_o_oval = fin_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind; r_imm <= n_imm; r_op <= n_op; r_cls <= n_cls;
        r_a <= n_a; r_b <= n_b; r_res <= n_res; r_rem <= n_rem; r_bit <= n_bit;
        r_cnt <= n_cnt; r_neg <= n_neg; r_dec <= n_dec;
        r_o_status <= n_o_status; r_o_next <= n_o_next;
        r_o_ov <= n_o_ov; r_o_oval <= n_o_oval;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLR;
            r_dd      <= '0;
            r_rd      <= '0;
            r_clr     <= '0;
            r_o_valid <= 1'b0;
            for (int i = 0; i < REGISTER_COUNT; i++) r_regs[i] <= '0;
        end else begin
            r_state   <= n_state;
            r_dd      <= n_dd;
            r_rd      <= n_rd;
            r_clr     <= n_clr;
            r_o_valid <= n_o_valid;
            if (reg_we) r_regs[r_imm[REG_AW-1:0]] <= reg_wdata;
        end
    end

    assign o_res_valid    = r_o_valid;
    assign o_status       = r_o_status;
    assign o_next_address = r_o_next;
    assign o_out_valid    = r_o_ov;
    assign o_out_value    = r_o_oval;

    a_dd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dd <= DEPTH_W'(STACK_DEPTH)) else $error("data depth out of range");
    a_rd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd <= DEPTH_W'(STACK_DEPTH)) else $error("return depth out of range");
    a_no_pop_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLR) |-> !o_pop) else $error("pop during clear");
    a_pop_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> out_free) else $error("pop with result slot busy");
endmodule
`default_nettype wire

/* rtl/stack_machine_execute_unit.sv */
`default_nettype none
// throughput: one instruction at a time in the back end, the iterative
//   divider (one quotient bit per cycle) bounds the worst case
// reset: synchronous active low; the byte ram is then cleared byte by byte,
//   during which no transaction is taken
// ----------------------------------------------------------------------------
// stack_machine_execute_unit
// stack machine instruction executor with front queue and execution back end
// ----------------------------------------------------------------------------
module stack_machine_execute_unit
    import sme_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [16:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [4:0]  i_kind,
    input  wire logic [31:0] i_immediate,
    input  wire logic [15:0] i_operand_address,
    input  wire logic [31:0] i_in_value,
    output logic             o_res_valid,
    input  wire logic        i_res_stall,
    output logic [2:0]       o_status,
    output logic [15:0]      o_next_address,
    output logic             o_out_valid,
    output logic [31:0]      o_out_value
);
    logic [16:0] r_program_size;
    logic        hold, pop, q_valid;
    t_item       item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_program_size <= PSIZE_MAX;
        end else if (i_cfg_we) begin
            r_program_size <= i_cfg_data;
        end
    end

    sme_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_kind(i_kind), .i_immediate(i_immediate),
        .i_operand_address(i_operand_address), .i_in_value(i_in_value),
        .i_program_size(r_program_size), .i_hold(hold), .i_pop(pop),
        .o_q_valid(q_valid), .o_item(item)
    );

    sme_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_program_size(r_program_size),
        .i_q_valid(q_valid), .i_item(item), .o_pop(pop), .o_hold(hold),
        .o_res_valid(o_res_valid), .i_res_stall(i_res_stall),
        .o_status(o_status), .o_next_address(o_next_address),
        .o_out_valid(o_out_valid), .o_out_value(o_out_value)
    );
endmodule
`default_nettype wire
